// ===== hw/rtl/bpcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_pkg
// Shared constants, types and the per-chunk planning function of the
// block I/O PRP command splitter.
// ----------------------------------------------------------------------------
package bpcs_pkg;

  // geometry (page and sector sizes are powers of two)
  localparam int unsigned PAGE_BYTES       = 4096;
  localparam int unsigned SECTOR_BYTES     = 512;
  localparam int unsigned LIST_CAP_SECTORS = 4096;
  localparam int unsigned MAX_SECTORS      = 256;
  localparam int unsigned ENTRY_CAP        = 32;
  localparam int unsigned RESULT_CAP       = 33;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // field widths
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BM1_W   = 12;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // derived widths
  localparam int unsigned PAGE_W   = $clog2(PAGE_BYTES);
  localparam int unsigned SECTOR_W = $clog2(SECTOR_BYTES);
  localparam int unsigned FIRST_W  = PAGE_W + 1;
  localparam int unsigned SPAN_W   = $clog2(PAGE_BYTES * (ENTRY_CAP + 1) + 1);
  localparam int unsigned NB_W     = CNT_W + SECTOR_W;
  localparam int unsigned MORE_W   = NB_W - PAGE_W + 1;
  localparam int unsigned N_W      = $clog2(RESULT_CAP + 1);
  localparam int unsigned TOT_W    = MORE_W + 1;
  localparam int unsigned PN_W     = ADDR_W - PAGE_W;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CMD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

  // command opcodes
  localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_PAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IO_EN     = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] list_page;
    logic              io_en;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              err;
    logic              wr;
    logic [ADDR_W-1:0] lba;
    logic [ADDR_W-1:0] buf_addr;
    logic [CNT_W-1:0]  cnt;
  } item_t;

  // plan of one chunk
  typedef struct packed {
    logic              cap0;
    logic [CNT_W-1:0]  cnt;
    logic [NB_W-1:0]   nbytes;
    logic [MORE_W-1:0] ent;
    logic              two_page;
  } chunk_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CHECK,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // size one chunk from the page offset and the sectors still to go
  function automatic chunk_t chunk_plan(input logic [PAGE_W-1:0] off,
                                        input logic [CNT_W-1:0]  sectors,
                                        input logic              has_list);
    logic [FIRST_W-1:0] first;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  cap;
    logic [NB_W-1:0]    diff;
    logic [MORE_W-1:0]  more;
    chunk_t             c;
    first = FIRST_W'(PAGE_BYTES) - FIRST_W'(off);
    if (has_list) begin
      span = SPAN_W'(first) + SPAN_W'(ENTRY_CAP * PAGE_BYTES);
    end else begin
      span = SPAN_W'(first) + SPAN_W'(PAGE_BYTES);
    end
    cap = span >> SECTOR_W;
    if (has_list && (cap > SPAN_W'(LIST_CAP_SECTORS))) begin
      cap = SPAN_W'(LIST_CAP_SECTORS);
    end
    c.cap0     = (cap == '0);
    c.cnt      = (SPAN_W'(sectors) > cap) ? CNT_W'(cap) : sectors;
    c.nbytes   = NB_W'(c.cnt) << SECTOR_W;
    c.ent      = '0;
    c.two_page = 1'b0;
    diff       = '0;
    more       = '0;
    if (c.nbytes > NB_W'(first)) begin
      diff = c.nbytes - NB_W'(first) + NB_W'(PAGE_BYTES - 1);
      more = MORE_W'(diff >> PAGE_W);
      c.two_page = (more == MORE_W'(1));
      c.ent      = (more > MORE_W'(1)) ? more : '0;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/bpcs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_in_if
// Request channel: valid/ready plus one block read or write request.
// ----------------------------------------------------------------------------
interface bpcs_in_if import bpcs_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              write_req;
  logic [ADDR_W-1:0] start_block;
  logic [ADDR_W-1:0] buffer_addr;
  logic [CNT_W-1:0]  sector_count;

  modport source (
    output valid, write_req, start_block, buffer_addr, sector_count,
    input  ready
  );

  modport sink (
    input  valid, write_req, start_block, buffer_addr, sector_count,
    output ready
  );
endinterface

// ===== hw/rtl/bpcs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_out_if
// Result channel: valid/ready plus one list entry, command or error.
// ----------------------------------------------------------------------------
interface bpcs_out_if import bpcs_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [OP_W-1:0]   cmd_opcode;
  logic [ADDR_W-1:0] cmd_lba;
  logic [ADDR_W-1:0] first_ptr;
  logic [ADDR_W-1:0] second_ptr;
  logic [BM1_W-1:0]  blocks_minus_one;
  logic [IDX_W-1:0]  entry_index;
  logic [ADDR_W-1:0] entry_value;
  logic              last;

  modport source (
    output valid, kind, cmd_opcode, cmd_lba, first_ptr, second_ptr,
           blocks_minus_one, entry_index, entry_value, last,
    input  ready
  );

  modport sink (
    input  valid, kind, cmd_opcode, cmd_lba, first_ptr, second_ptr,
           blocks_minus_one, entry_index, entry_value, last,
    output ready
  );
endinterface

// ===== hw/rtl/bpcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_front
// Takes requests, screens them and walks their chunks once to count results,
// then hands an ok or error item to the queue.
// ----------------------------------------------------------------------------
module bpcs_front import bpcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bpcs_in_if.sink     in_chan,
  input  cfg_t        cfg,
  output logic        push_valid,
  input  logic        push_ready,
  output item_t       push_item
);

  front_state_t      state_r, state_nxt;
  item_t             item_r, item_nxt;
  logic [PAGE_W-1:0] off_r, off_nxt;
  logic [CNT_W-1:0]  sec_r, sec_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  chunk_t            chunk;
  logic [TOT_W-1:0]  total;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working copy of the request
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    off_r  <= off_nxt;
    sec_r  <= sec_nxt;
    n_r    <= n_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    off_nxt    = off_r;
    sec_nxt    = sec_r;
    n_nxt      = n_r;
    in_chan.ready = 1'b0;
    push_valid = 1'b0;
    push_item  = item_r;
    chunk      = chunk_plan(off_r, sec_r, |cfg.list_page);
    total      = TOT_W'(n_r) + TOT_W'(chunk.ent) + TOT_W'(1);
    case (state_r)
      F_IDLE: begin
        // no transfer is taken while reset is held
        in_chan.ready = rst_n;
        if (in_chan.valid) begin
          item_nxt.err      = 1'b0;
          item_nxt.wr       = in_chan.write_req;
          item_nxt.lba      = in_chan.start_block;
          item_nxt.buf_addr = in_chan.buffer_addr;
          item_nxt.cnt      = in_chan.sector_count;
          off_nxt           = in_chan.buffer_addr[PAGE_W-1:0];
          sec_nxt           = in_chan.sector_count;
          n_nxt             = '0;
          if (!cfg.io_en || (in_chan.sector_count > CNT_W'(MAX_SECTORS))) begin
            item_nxt.err = 1'b1;
            state_nxt    = F_PUSH;
          end else if (in_chan.sector_count != '0) begin
            state_nxt = F_CHECK;
          end
        end
      end
      // one chunk per cycle, refuse once the result budget is blown
      F_CHECK: begin
        if (chunk.cap0 || (total > TOT_W'(RESULT_CAP))) begin
          item_nxt.err = 1'b1;
          state_nxt    = F_PUSH;
        end else if (sec_r == chunk.cnt) begin
          state_nxt = F_PUSH;
        end else begin
          off_nxt = off_r + PAGE_W'(chunk.nbytes);
          sec_nxt = sec_r - chunk.cnt;
          n_nxt   = N_W'(total);
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bpcs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module bpcs_queue import bpcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_QW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_QW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/bpcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_back
// Walks the chunks of a checked request and emits list entries and commands
// (or an error result) via a registered output stage, one result per cycle while out_chan is ready.
// ----------------------------------------------------------------------------
module bpcs_back import bpcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_item,
  bpcs_out_if.source  out_chan
);

  back_state_t        state_r, state_nxt;
  logic               wr_r, wr_nxt;
  logic [ADDR_W-1:0]  lba_r, lba_nxt;
  logic [ADDR_W-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]   sec_r, sec_nxt;
  logic [MORE_W-1:0]  i_r, i_nxt;

  // output stage
  logic               ov_r, ov_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [ADDR_W-1:0]  clba_r, clba_nxt;
  logic [ADDR_W-1:0]  p1_r, p1_nxt;
  logic [ADDR_W-1:0]  p2_r, p2_nxt;
  logic [BM1_W-1:0]   bm1_r, bm1_nxt;
  logic [IDX_W-1:0]   eidx_r, eidx_nxt;
  logic [ADDR_W-1:0]  eval_r, eval_nxt;
  logic               last_r, last_nxt;

  logic               load_ok;
  chunk_t             chunk;
  logic [PN_W-1:0]    next_page;
  logic [PN_W-1:0]    entry_page;

  assign out_chan.valid            = ov_r;
  assign out_chan.kind             = kind_r;
  assign out_chan.cmd_opcode       = op_r;
  assign out_chan.cmd_lba          = clba_r;
  assign out_chan.first_ptr        = p1_r;
  assign out_chan.second_ptr       = p2_r;
  assign out_chan.blocks_minus_one = bm1_r;
  assign out_chan.entry_index      = eidx_r;
  assign out_chan.entry_value      = eval_r;
  assign out_chan.last             = last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // request walk and result payload
  always_ff @(posedge clk) begin
    wr_r   <= wr_nxt;
    lba_r  <= lba_nxt;
    buf_r  <= buf_nxt;
    sec_r  <= sec_nxt;
    i_r    <= i_nxt;
    kind_r <= kind_nxt;
    op_r   <= op_nxt;
    clba_r <= clba_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    bm1_r  <= bm1_nxt;
    eidx_r <= eidx_nxt;
    eval_r <= eval_nxt;
    last_r <= last_nxt;
  end

  // next state and results
  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    lba_nxt   = lba_r;
    buf_nxt   = buf_r;
    sec_nxt   = sec_r;
    i_nxt     = i_r;
    kind_nxt  = kind_r;
    op_nxt    = op_r;
    clba_nxt  = clba_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    bm1_nxt   = bm1_r;
    eidx_nxt  = eidx_r;
    eval_nxt  = eval_r;
    last_nxt  = last_r;
    pop_ready = 1'b0;

    // slot frees when the held result is taken
    load_ok = !ov_r || out_chan.ready;
    ov_nxt  = ov_r && !out_chan.ready;

    chunk      = chunk_plan(buf_r[PAGE_W-1:0], sec_r, |cfg.list_page);
    next_page  = buf_r[ADDR_W-1:PAGE_W] + PN_W'(1);
    entry_page = next_page + PN_W'(i_r);

    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_item.err) begin
            if (load_ok) begin
              pop_ready = 1'b1;
              ov_nxt    = 1'b1;
              kind_nxt  = KIND_ERR;
              op_nxt    = OP_NONE;
              clba_nxt  = '0;
              p1_nxt    = '0;
              p2_nxt    = '0;
              bm1_nxt   = '0;
              eidx_nxt  = '0;
              eval_nxt  = '0;
              last_nxt  = 1'b1;
            end
          end else begin
            pop_ready = 1'b1;
            wr_nxt    = pop_item.wr;
            lba_nxt   = pop_item.lba;
            buf_nxt   = pop_item.buf_addr;
            sec_nxt   = pop_item.cnt;
            i_nxt     = '0;
            state_nxt = B_RUN;
          end
        end
      end
      B_RUN: begin
        if (load_ok) begin
          ov_nxt = 1'b1;
          if ((chunk.ent != '0) && (i_r != chunk.ent)) begin
            // list entry ahead of its command
            kind_nxt = KIND_ENTRY;
            op_nxt   = OP_NONE;
            clba_nxt = '0;
            p1_nxt   = '0;
            p2_nxt   = '0;
            bm1_nxt  = '0;
            eidx_nxt = i_r[IDX_W-1:0];
            eval_nxt = {entry_page, {PAGE_W{1'b0}}};
            last_nxt = 1'b0;
            i_nxt    = i_r + MORE_W'(1);
          end else begin
            // the command itself, then step to the next chunk
            kind_nxt = KIND_CMD;
            op_nxt   = wr_r ? OP_WRITE : OP_READ;
            clba_nxt = lba_r;
            p1_nxt   = buf_r;
            if (chunk.ent != '0) begin
              p2_nxt = cfg.list_page;
            end else if (chunk.two_page) begin
              p2_nxt = {next_page, {PAGE_W{1'b0}}};
            end else begin
              p2_nxt = '0;
            end
            bm1_nxt  = BM1_W'(chunk.cnt) - BM1_W'(1);
            eidx_nxt = '0;
            eval_nxt = '0;
            last_nxt = (sec_r == chunk.cnt);
            i_nxt    = '0;
            buf_nxt  = buf_r + ADDR_W'(chunk.nbytes);
            lba_nxt  = lba_r + ADDR_W'(chunk.cnt);
            sec_nxt  = sec_r - chunk.cnt;
            if (sec_r == chunk.cnt) begin
              state_nxt = B_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/block_io_prp_command_splitter_unit.sv =====
`timescale 1ns / 1ps
// Flow: a request is taken in F_IDLE, the front walks its chunks in F_CHECK
// counting results and queues it from F_PUSH; the back pops it and registers
// its results in its output stage (an error result is registered as it is popped).
// Throughput: one result per cycle while out_chan is ready; the front takes the
// next request while the back is still emitting the results of the last.
// Reset: synchronous; clears both configuration registers, the queue and control.
// ----------------------------------------------------------------------------
// block_io_prp_command_splitter_unit
// Splits block read/write requests into NVMe commands with PRP list entries.
// ----------------------------------------------------------------------------
module block_io_prp_command_splitter_unit import bpcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bpcs_in_if.sink              in_chan,
  bpcs_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  logic [ADDR_W-1:0] list_page_r;
  logic              io_en_r;
  cfg_t              cfg;
  logic              push_valid, push_ready;
  item_t             push_item;
  logic              pop_valid, pop_ready;
  item_t             pop_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_page_r <= '0;
      io_en_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LIST_PAGE: list_page_r <= cfg_wdata;
        CFG_IO_EN:     io_en_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.list_page = list_page_r;
  assign cfg.io_en     = io_en_r;

  // request screening and result counting
  bpcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  bpcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // result generation
  bpcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_chan  (out_chan)
  );

endmodule
